// ===== rtl/pid_controller_clamped_defines.svh =====
// Assertion macros shared by the files that check their own logic.
// Each macro expands to a concurrent assertion clocked on i_clk and disabled
// while i_rst_n is low; synthesis builds see empty bodies.
`ifndef PID_CONTROLLER_CLAMPED_DEFINES_SVH
`define PID_CONTROLLER_CLAMPED_DEFINES_SVH

`ifndef SYNTHESIS
`define PIDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define PIDC_ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error(msg);
`else
`define PIDC_ASSERT(lbl, prop, msg)
`define PIDC_ASSERT_NEXT(lbl, cond, nxt, msg)
`endif

`endif

// ===== rtl/pidc_pkg.sv =====
`timescale 1ns / 1ps

package pidc_pkg;

    // Configuration port geometry: seven 32-bit registers at 4-byte spacing.
    localparam int C_PADDR_W = 5;

    // Milliseconds per second, used to turn dt into seconds and back.
    localparam logic [31:0] C_MS_PER_S = 32'd1000;

    // Division by 1000 is done one 16-bit digit at a time by multiplying with
    // ceil(2^36 / 1000). With a partial remainder below 1000 each step's
    // dividend stays below 2^26, where the product shifted down by 36 is the
    // exact quotient digit.
    localparam logic [31:0] C_RECIP_1000  = 32'd68719477;
    localparam int          C_RECIP_SHIFT = 36;
    localparam int          C_DIGIT_W     = 16;
    localparam logic [1:0]  C_DIGITS_M1   = 2'd3;

    // The divider retires one quotient bit per cycle over a 64-bit dividend.
    localparam int C_DIV_W     = 64;
    localparam int C_DIV_CNT_W = 6;

    typedef enum logic [2:0] {
        REG_GAIN_P      = 3'd0,
        REG_GAIN_I      = 3'd1,
        REG_GAIN_D      = 3'd2,
        REG_OUT_LOWER   = 3'd3,
        REG_OUT_UPPER   = 3'd4,
        REG_ACCUM_LOWER = 3'd5,
        REG_ACCUM_UPPER = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] gain_p;
        logic signed [31:0] gain_i;
        logic signed [31:0] gain_d;
        logic signed [31:0] out_lower;
        logic signed [31:0] out_upper;
        logic signed [31:0] accum_lower;
        logic signed [31:0] accum_upper;
    } t_cfg;

    typedef struct packed {
        logic                 start;
        logic [C_DIV_W-1:0]   dividend;
        logic [31:0]          divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [C_DIV_W-1:0]   quot;
    } t_div_rsp;

    typedef enum logic [15:0] {
        S_IDLE = 16'd1,
        S_ERR  = 16'd2,
        S_MUL1 = 16'd4,
        S_MUL2 = 16'd8,
        S_DIV  = 16'd16,
        S_RM   = 16'd32,
        S_RQ   = 16'd64,
        S_ISUM = 16'd128,
        S_ACC  = 16'd256,
        S_DW   = 16'd512,
        S_TP   = 16'd1024,
        S_TI   = 16'd2048,
        S_TD   = 16'd4096,
        S_TL   = 16'd8192,
        S_SUM  = 16'd16384,
        S_FIN  = 16'd32768
    } t_state;

endpackage

// ===== rtl/pidc_if.sv =====
`timescale 1ns / 1ps

// Input channel: one control request per word.
interface pidc_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [31:0] target;
    logic signed [31:0] measured;
    logic [31:0]        now_ms;

    modport source (output valid, command, target, measured, now_ms, input ready);
    modport sink   (input valid, command, target, measured, now_ms, output ready);
endinterface

// Output channel: one drive value per word.
interface pidc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive;

    modport source (output valid, drive, input ready);
    modport sink   (input valid, drive, output ready);
endinterface

// ===== rtl/pidc_regs.sv =====
`timescale 1ns / 1ps

module pidc_regs #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pidc_pkg::C_PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output pidc_pkg::t_cfg                o_cfg
);
    import pidc_pkg::*;

    localparam logic signed [31:0] L_ONE       = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] L_MINUS_ONE = -L_ONE;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[C_PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p      <= '0;
            r_cfg.gain_i      <= '0;
            r_cfg.gain_d      <= '0;
            r_cfg.out_lower   <= L_MINUS_ONE;
            r_cfg.out_upper   <= L_ONE;
            r_cfg.accum_lower <= L_MINUS_ONE;
            r_cfg.accum_upper <= L_ONE;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_GAIN_P:      r_cfg.gain_p      <= $signed(pwdata);
                REG_GAIN_I:      r_cfg.gain_i      <= $signed(pwdata);
                REG_GAIN_D:      r_cfg.gain_d      <= $signed(pwdata);
                REG_OUT_LOWER:   r_cfg.out_lower   <= $signed(pwdata);
                REG_OUT_UPPER:   r_cfg.out_upper   <= $signed(pwdata);
                REG_ACCUM_LOWER: r_cfg.accum_lower <= $signed(pwdata);
                REG_ACCUM_UPPER: r_cfg.accum_upper <= $signed(pwdata);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_GAIN_P:      prdata = r_cfg.gain_p;
            REG_GAIN_I:      prdata = r_cfg.gain_i;
            REG_GAIN_D:      prdata = r_cfg.gain_d;
            REG_OUT_LOWER:   prdata = r_cfg.out_lower;
            REG_OUT_UPPER:   prdata = r_cfg.out_upper;
            REG_ACCUM_LOWER: prdata = r_cfg.accum_lower;
            REG_ACCUM_UPPER: prdata = r_cfg.accum_upper;
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== rtl/pidc_mul.sv =====
`timescale 1ns / 1ps

module pidc_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    // Unsigned magnitudes in, registered product out.
    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== rtl/pidc_div.sv =====
`timescale 1ns / 1ps

module pidc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pidc_pkg::t_div_req i_req,
    output pidc_pkg::t_div_rsp o_rsp
);
    import pidc_pkg::*;

    // Restoring division, one quotient bit per cycle. The quotient shifts in
    // behind the dividend bits as they are consumed.
    logic                   r_busy;
    logic                   r_done;
    logic [C_DIV_CNT_W-1:0] r_cnt;
    logic [31:0]            r_rem;
    logic [31:0]            r_den;
    logic [C_DIV_W-1:0]     r_quo;

    logic [32:0] w_rem_sh;
    logic [32:0] w_rem_nx;
    logic        w_ge;

    assign w_rem_sh = {r_rem, r_quo[C_DIV_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_den};
    assign w_rem_nx = w_ge ? (w_rem_sh - {1'b0, r_den}) : w_rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= C_DIV_CNT_W'(C_DIV_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_den <= i_req.divisor;
            r_quo <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= w_rem_nx[31:0];
            r_quo <= {r_quo[C_DIV_W-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

// ===== rtl/pid_controller_clamped.sv =====
`timescale 1ns / 1ps

// PID controller with integral clamping for anti-windup, in signed fixed point
// with FRAC_BITS fraction bits (Q16.16 by default). Each input word either
// computes one update (command 0) or restarts the controller (command 1);
// every input word gives exactly one output word. A compute word spends most
// of its time waiting for the 64-step pass through the bit-serial divider
// that forms (error-last error)*1000/dt for the derivative. Meanwhile the
// shared registered 32x32 multiplier forms error*dt and divides it by 1000
// through a reciprocal multiplication, one 16-bit digit per pass through
// the RM and RQ steps, and later forms the three gain terms. A restart word
// goes straight to the final step. The input is taken only while the
// sequencer is idle, and the finished drive value sits in an output register,
// so a new word may be accepted while the previous result still waits to be
// taken; a word that finishes while an earlier result is still waiting holds
// in its last step until that result is taken. Gains and limits are written
// over the APB-style port at byte address 4*i and must only be changed while
// no word is in flight.

`include "pid_controller_clamped_defines.svh"

module pid_controller_clamped #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pidc_in_if.sink                        i_in,
    pidc_out_if.source                     o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pidc_pkg::C_PADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import pidc_pkg::*;

    localparam logic signed [64:0] L_SAT_MAX = 65'sd2147483647;
    localparam logic signed [64:0] L_SAT_MIN = -65'sd2147483648;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] f_sat32(input logic signed [64:0] x);
        if (x > L_SAT_MAX) begin
            return L_SAT_MAX[31:0];
        end else if (x < L_SAT_MIN) begin
            return L_SAT_MIN[31:0];
        end
        return $signed(x[31:0]);
    endfunction

    // When the limits cross, a value below the lower bound gives the lower bound and any other value the upper bound.
    function automatic logic signed [31:0] f_clamp(input logic signed [31:0] x,
                                                   input logic signed [31:0] lo,
                                                   input logic signed [31:0] hi);
        if (x < lo) begin
            return lo;
        end else if (x > hi) begin
            return hi;
        end
        return x;
    endfunction

    // Magnitude of a signed word; the most negative value maps to 2^31.
    function automatic logic [31:0] f_abs32(input logic signed [31:0] x);
        return x[31] ? 32'(-x) : 32'(x);
    endfunction

    // Re-apply a sign to a magnitude from the multiplier or the divider.
    function automatic logic signed [64:0] f_signed(input logic [63:0] mag,
                                                    input logic        neg);
        logic signed [64:0] m;
        m = $signed({1'b0, mag});
        return neg ? -m : m;
    endfunction

    t_cfg     w_cfg;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    t_state r_state;
    t_state n_state;

    // Captured input word.
    logic               r_cmd;
    logic signed [31:0] r_tgt;
    logic signed [31:0] r_meas;
    logic [31:0]        r_now;

    // Controller state kept between words.
    logic signed [31:0] r_accum;
    logic signed [31:0] r_prev_error;
    logic [31:0]        r_prev_time;

    // Working values of the current update.
    logic [31:0]        r_dt;
    logic signed [31:0] r_err;
    logic signed [32:0] r_diff;
    logic signed [64:0] r_sum;
    logic signed [31:0] r_acc_new;
    logic signed [31:0] r_deriv;
    logic signed [31:0] r_term_p;
    logic signed [31:0] r_term_i;
    logic signed [31:0] r_term_d;
    logic signed [31:0] r_res;

    // Digit-by-digit division of |error|*dt by 1000.
    logic [63:0]        r_nd;
    logic [9:0]         r_rem;
    logic [63:0]        r_quo;
    logic [1:0]         r_dig;

    // Output register.
    logic               r_out_valid;
    logic signed [31:0] r_drive;

    logic [31:0]        w_mul_a;
    logic [31:0]        w_mul_b;
    logic [63:0]        w_mul_p;
    logic               w_term_neg;
    logic signed [64:0] w_term_shift;
    logic signed [31:0] w_term;
    logic [31:0]        w_dt_raw;
    logic [31:0]        w_diff_mag;
    logic signed [64:0] w_pid_sum;
    logic [25:0]        w_x;
    logic [15:0]        w_q;
    logic [25:0]        w_rem_nx;
    logic               w_accept;
    logic               w_load;

    pidc_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pidc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    pidc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_accept    = i_in.valid && (r_state == S_IDLE);
    assign w_load      = (r_state == S_FIN) && (!r_out_valid || o_out.ready);
    assign o_out.valid = r_out_valid;
    assign o_out.drive = r_drive;

    assign w_dt_raw   = r_now - r_prev_time;
    assign w_diff_mag = r_diff[32] ? 32'(-r_diff) : r_diff[31:0];
    assign w_pid_sum  = 65'(r_term_p) + 65'(r_term_i) + 65'(r_term_d);

    // One step of the division by 1000: the partial remainder followed by the
    // next 16-bit digit, its quotient digit from the reciprocal product, and
    // the new remainder.
    assign w_x      = {r_rem, r_nd[63:48]};
    assign w_q      = w_mul_p[C_RECIP_SHIFT+C_DIGIT_W-1:C_RECIP_SHIFT];
    assign w_rem_nx = w_x - 26'(w_q) * 26'(C_MS_PER_S);

    // The divider only forms the derivative: the scaled error change over dt.
    // Its dividend is the product issued in S_MUL2, which the multiplier register holds when S_DIV starts it.
    assign w_div_req.start    = (r_state == S_DIV);
    assign w_div_req.dividend = w_mul_p;
    assign w_div_req.divisor  = r_dt;

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_a    = '0;
        w_mul_b    = '0;
        w_term_neg = 1'b0;
        unique case (r_state)
            S_MUL1: begin
                w_mul_a = f_abs32(r_err);
                w_mul_b = r_dt;
            end
            S_MUL2: begin
                w_mul_a = w_diff_mag;
                w_mul_b = C_MS_PER_S;
            end
            S_RM: begin
                w_mul_a = 32'(w_x);
                w_mul_b = C_RECIP_1000;
            end
            S_TP: begin
                w_mul_a = f_abs32(w_cfg.gain_p);
                w_mul_b = f_abs32(r_err);
            end
            S_TI: begin
                w_mul_a    = f_abs32(w_cfg.gain_i);
                w_mul_b    = f_abs32(r_acc_new);
                w_term_neg = w_cfg.gain_p[31] ^ r_err[31];
            end
            S_TD: begin
                w_mul_a    = f_abs32(w_cfg.gain_d);
                w_mul_b    = f_abs32(r_deriv);
                w_term_neg = w_cfg.gain_i[31] ^ r_acc_new[31];
            end
            S_TL: begin
                w_term_neg = w_cfg.gain_d[31] ^ r_deriv[31];
            end
            default: ;
        endcase
    end

    // Each gain term is the signed product shifted down with rounding
    // towards minus infinity, which an arithmetic shift gives directly.
    assign w_term_shift = f_signed(w_mul_p, w_term_neg) >>> FRAC_BITS;
    assign w_term       = f_sat32(w_term_shift);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = i_in.command ? S_FIN : S_ERR;
                end
            end
            S_ERR:  n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_DIV;
            S_DIV:  n_state = S_RM;
            S_RM:   n_state = S_RQ;
            S_RQ: begin
                if (r_dig == '0) begin
                    n_state = S_ISUM;
                end else begin
                    n_state = S_RM;
                end
            end
            S_ISUM: n_state = S_ACC;
            S_ACC:  n_state = S_DW;
            S_DW: begin
                if (w_div_rsp.done) begin
                    n_state = S_TP;
                end
            end
            S_TP:   n_state = S_TI;
            S_TI:   n_state = S_TD;
            S_TD:   n_state = S_TL;
            S_TL:   n_state = S_SUM;
            S_SUM:  n_state = S_FIN;
            S_FIN: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Controller state is only committed once the result is loaded into the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum      <= '0;
            r_prev_error <= '0;
            r_prev_time  <= '0;
        end else if (w_load) begin
            r_prev_time <= r_now;
            if (r_cmd) begin
                r_accum      <= '0;
                r_prev_error <= '0;
            end else begin
                r_accum      <= r_acc_new;
                r_prev_error <= r_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_drive <= r_res;
        end
    end

    // Datapath of the sequencer.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_cmd  <= i_in.command;
                    r_tgt  <= i_in.target;
                    r_meas <= i_in.measured;
                    r_now  <= i_in.now_ms;
                    r_res  <= '0;
                end
            end
            S_ERR: begin
                // A zero elapsed time counts as one millisecond.
                r_dt  <= (w_dt_raw == '0) ? 32'd1 : w_dt_raw;
                r_err <= f_sat32(65'(r_tgt) - 65'(r_meas));
            end
            S_MUL1: begin
                r_diff <= 33'(r_err) - 33'(r_prev_error);
            end
            S_MUL2: begin
                // |error|*dt is ready; it is divided from its top digit down.
                r_nd  <= w_mul_p;
                r_rem <= '0;
                r_quo <= '0;
                r_dig <= C_DIGITS_M1;
            end
            S_RQ: begin
                r_rem <= w_rem_nx[9:0];
                r_quo <= {r_quo[47:0], w_q};
                r_nd  <= {r_nd[47:0], 16'd0};
                r_dig <= r_dig - 2'd1;
            end
            S_ISUM: begin
                r_sum <= 65'(r_accum) + f_signed(r_quo, r_err[31]);
            end
            S_ACC: begin
                r_acc_new <= f_clamp(f_sat32(r_sum), w_cfg.accum_lower, w_cfg.accum_upper);
            end
            S_DW: begin
                if (w_div_rsp.done) begin
                    r_deriv <= f_sat32(f_signed(w_div_rsp.quot, r_diff[32]));
                end
            end
            S_TI: r_term_p <= w_term;
            S_TD: r_term_i <= w_term;
            S_TL: r_term_d <= w_term;
            S_SUM: begin
                r_res <= f_clamp(f_sat32(w_pid_sum), w_cfg.out_lower, w_cfg.out_upper);
            end
            default: ;
        endcase
    end

    // An accepted word always sets the sequencer going.
    `PIDC_ASSERT_NEXT(a_accept_leaves_idle, i_in.valid && i_in.ready, r_state != S_IDLE, "accepted word left the sequencer idle")

    // The divider reports completion only while the sequencer waits for it.
    `PIDC_ASSERT(a_div_done_in_wait, w_div_rsp.done |-> (r_state == S_DW), "divider finished outside a wait step")

    // With ordered limits, a waiting result lies inside them or is a restart zero.
    `PIDC_ASSERT(a_drive_in_limits, (o_out.valid && (w_cfg.out_lower <= w_cfg.out_upper)) |-> ((o_out.drive == 32'sd0) || ((o_out.drive >= w_cfg.out_lower) && (o_out.drive <= w_cfg.out_upper))), "drive outside output limits")

endmodule
